// File: hw/rtl/lpfa_pkg.sv
// shared constants, types and codes of the length-prefixed frame assembler
package lpfa_pkg;

  localparam int MAX_FRAME_BYTES = 1024;
  localparam int HEADER_BYTES    = 6;
  localparam int CHECKSUM_BYTES  = 2;
  localparam int LEN_LOW_POS     = 4;
  localparam int LEN_HIGH_POS    = 5;

  localparam int FRAME_W  = 11;
  localparam int POS_W    = 10;
  localparam int TIME_W   = 32;
  localparam int GAP_W    = 16;
  localparam int MAXPL_W  = 10;
  localparam int BYTE_W   = 8;
  localparam int STATUS_W = 2;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CFG_IDX_W-1:0] CFG_START_BYTE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAP_TIMEOUT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_PAYLOAD = 2'd2;

  localparam logic [STATUS_W-1:0] STS_BUSY    = 2'd0;
  localparam logic [STATUS_W-1:0] STS_DONE    = 2'd1;
  localparam logic [STATUS_W-1:0] STS_TIMEOUT = 2'd2;
  localparam logic [STATUS_W-1:0] STS_BAD_LEN = 2'd3;

  localparam logic [BYTE_W-1:0]  START_BYTE_RST  = 8'd165;
  localparam logic [GAP_W-1:0]   GAP_TIMEOUT_RST = 16'd1000;
  localparam logic [MAXPL_W-1:0] MAX_PAYLOAD_RST = 10'd1016;

  typedef struct packed {
    logic [BYTE_W-1:0]  start_byte;
    logic [GAP_W-1:0]   gap_timeout_ms;
    logic [MAXPL_W-1:0] max_payload;
  } cfg_t;

  typedef struct packed {
    logic              byte_offered;
    logic              is_start;
    logic [BYTE_W-1:0] rx_byte;
    logic [TIME_W-1:0] now_ms;
  } item_t;

endpackage

// File: hw/rtl/lpfa_if.sv
// valid/ready channel interfaces for poll words and result words
interface lpfa_in_if import lpfa_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              operation;
  logic [BYTE_W-1:0] rx_byte;
  logic [TIME_W-1:0] now_ms;

  modport source (output valid, operation, rx_byte, now_ms, input ready);
  modport sink (input valid, operation, rx_byte, now_ms, output ready);
endinterface

interface lpfa_out_if import lpfa_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic                byte_taken;
  logic                byte_stored;
  logic [BYTE_W-1:0]   stored_byte;
  logic [POS_W-1:0]    byte_position;
  logic [FRAME_W-1:0]  frame_length;

  modport source (output valid, status, byte_taken, byte_stored, stored_byte, byte_position,
                  frame_length, input ready);
  modport sink (input valid, status, byte_taken, byte_stored, stored_byte, byte_position,
                frame_length, output ready);
endinterface

// File: hw/rtl/lpfa_front.sv
// front end: accepts poll words, classifies them and queues them for the back end
module lpfa_front import lpfa_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  lpfa_in_if.sink           in_ch,
  input  logic [BYTE_W-1:0] start_byte,
  output logic              q_valid,
  output item_t             q_item,
  input  logic              q_pop
);

  item_t               mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]   count_r, count_nxt;
  logic                push;
  logic                pop;
  item_t               new_item;

  assign in_ch.ready = (count_r != QCNT_W'(QUEUE_DEPTH));
  assign push        = in_ch.valid && in_ch.ready;
  assign q_valid     = (count_r != '0);
  assign pop         = q_pop && q_valid;
  assign q_item      = mem_r[rd_ptr_r];

  always_comb begin
    new_item.byte_offered = in_ch.operation;
    new_item.is_start     = (in_ch.rx_byte == start_byte);
    new_item.rx_byte      = in_ch.rx_byte;
    new_item.now_ms       = in_ch.now_ms;
  end

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + QCNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= new_item;
    end
  end

endmodule

// File: hw/rtl/lpfa_back.sv
// back end: frame state, timeout and length checks, and the result register
module lpfa_back import lpfa_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  cfg_t     cfg,
  input  logic     q_valid,
  input  item_t    q_item,
  output logic     q_pop,
  lpfa_out_if.source out_ch
);

  logic [FRAME_W-1:0]  held_r, held_nxt;
  logic [FRAME_W-1:0]  exp_r, exp_nxt;
  logic [TIME_W-1:0]   last_r, last_nxt;
  logic [BYTE_W-1:0]   low_r, low_nxt;
  logic [BYTE_W-1:0]   high_r, high_nxt;

  logic                out_valid_r;
  logic [STATUS_W-1:0] status_r, status_nxt;
  logic                taken_r, taken_nxt;
  logic                stored_r, stored_nxt;
  logic [BYTE_W-1:0]   sbyte_r, sbyte_nxt;
  logic [POS_W-1:0]    pos_r, pos_nxt;
  logic [FRAME_W-1:0]  flen_r, flen_nxt;

  logic [TIME_W-1:0]   gap;
  logic                timed_out;
  logic [FRAME_W-1:0]  held_inc;
  logic [2*BYTE_W-1:0] payload;
  logic                drop;

  assign q_pop = q_valid && (!out_valid_r || out_ch.ready);

  assign gap       = q_item.now_ms - last_r;
  assign timed_out = (held_r != '0) && (gap > TIME_W'(cfg.gap_timeout_ms));
  assign held_inc  = held_r + FRAME_W'(1);

  always_comb begin
    held_nxt   = held_r;
    exp_nxt    = exp_r;
    last_nxt   = last_r;
    low_nxt    = low_r;
    high_nxt   = high_r;
    status_nxt = STS_BUSY;
    taken_nxt  = 1'b0;
    stored_nxt = 1'b0;
    sbyte_nxt  = '0;
    pos_nxt    = '0;
    flen_nxt   = '0;
    drop       = 1'b0;
    payload    = '0;
    if (timed_out) begin
      drop       = 1'b1;
      status_nxt = STS_TIMEOUT;
    end else if (q_item.byte_offered) begin
      taken_nxt = 1'b1;
      last_nxt  = q_item.now_ms;
      if (held_r == '0 && !q_item.is_start) begin
        status_nxt = STS_BUSY;
      end else if (held_r >= FRAME_W'(MAX_FRAME_BYTES)) begin
        drop       = 1'b1;
        status_nxt = STS_BAD_LEN;
      end else begin
        stored_nxt = 1'b1;
        sbyte_nxt  = q_item.rx_byte;
        pos_nxt    = held_r[POS_W-1:0];
        if (held_r == FRAME_W'(LEN_LOW_POS)) begin
          low_nxt = q_item.rx_byte;
        end
        if (held_r == FRAME_W'(LEN_HIGH_POS)) begin
          high_nxt = q_item.rx_byte;
        end
        held_nxt = held_inc;
        if (held_inc == FRAME_W'(HEADER_BYTES)) begin
          payload = {high_nxt, low_nxt};
          if (payload > (2*BYTE_W)'(cfg.max_payload)) begin
            drop       = 1'b1;
            status_nxt = STS_BAD_LEN;
          end else begin
            exp_nxt = FRAME_W'(HEADER_BYTES) + payload[FRAME_W-1:0] +
                      FRAME_W'(CHECKSUM_BYTES);
          end
        end
        if (!drop && exp_nxt != '0 && held_inc == exp_nxt) begin
          status_nxt = STS_DONE;
          flen_nxt   = held_inc;
          drop       = 1'b1;
        end
      end
    end
    if (drop) begin
      held_nxt = '0;
      exp_nxt  = '0;
      low_nxt  = '0;
      high_nxt = '0;
      last_nxt = q_item.now_ms;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r      <= '0;
      exp_r       <= '0;
      last_r      <= '0;
      low_r       <= '0;
      high_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (q_pop) begin
        held_r      <= held_nxt;
        exp_r       <= exp_nxt;
        last_r      <= last_nxt;
        low_r       <= low_nxt;
        high_r      <= high_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      status_r <= status_nxt;
      taken_r  <= taken_nxt;
      stored_r <= stored_nxt;
      sbyte_r  <= sbyte_nxt;
      pos_r    <= pos_nxt;
      flen_r   <= flen_nxt;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.status        = status_r;
  assign out_ch.byte_taken    = taken_r;
  assign out_ch.byte_stored   = stored_r;
  assign out_ch.stored_byte   = sbyte_r;
  assign out_ch.byte_position = pos_r;
  assign out_ch.frame_length  = flen_r;

endmodule

// File: hw/rtl/length_prefixed_frame_assembler.sv
// top level of the length-prefixed frame assembler
//
// in_ch carries one poll word per handshake: operation (byte offered or not),
// rx_byte and a wrapping millisecond timestamp now_ms. out_ch returns exactly
// one result word per poll word, in order: status, whether the byte was taken
// and stored, the stored byte with its frame position, and the frame length
// on completion. A byte refused on timeout must be offered again by the source.
// Result valid rises once the word has passed the queue and the result register.
// The throughput is one word per cycle while out_ch is read, set by the frame
// state update in the back end.
// A 2-word queue sits between front and back, and the result
// register frees as it is taken, so in_ch stays ready while out_ch is read
// every cycle. When out_ch stalls the result holds, the queue fills and
// in_ch.ready drops after two more words. cfg_we writes start_byte (index 0),
// gap_timeout_ms (1) or max_payload (2) from cfg_data; other indexes are ignored.
// Synchronous reset clears the frame state and the queue, empties the output
// and restores start_byte 165, timeout 1000 and max payload 1016.
module length_prefixed_frame_assembler import lpfa_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  lpfa_in_if.sink               in_ch,
  lpfa_out_if.source            out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t  cfg_r;
  logic  q_valid;
  item_t q_item;
  logic  q_pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_byte     <= START_BYTE_RST;
      cfg_r.gap_timeout_ms <= GAP_TIMEOUT_RST;
      cfg_r.max_payload    <= MAX_PAYLOAD_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_START_BYTE:  cfg_r.start_byte     <= cfg_data[BYTE_W-1:0];
        CFG_GAP_TIMEOUT: cfg_r.gap_timeout_ms <= cfg_data[GAP_W-1:0];
        CFG_MAX_PAYLOAD: cfg_r.max_payload    <= cfg_data[MAXPL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  lpfa_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .start_byte (cfg_r.start_byte),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop)
  );

  lpfa_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

  a_stored_needs_taken: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.byte_stored |-> out_ch.byte_taken)
    else $error("stored word not marked taken");

  a_done_has_length: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.status == STS_DONE |->
      out_ch.byte_stored && out_ch.frame_length != '0)
    else $error("completed frame without length or stored word");

  a_timeout_takes_nothing: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.status == STS_TIMEOUT |->
      !out_ch.byte_taken && !out_ch.byte_stored)
    else $error("timeout abort consumed a word");

  a_empty_after_reset: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_ch.valid)
    else $error("result valid right after reset");

endmodule
